/* rtl/core/hkcf_pkg.sv */
// hkcf_pkg: constants, types and helpers shared by the hex key candidate filter
// no dependencies
package hkcf_pkg;

    localparam int WORD_LEN   = 10;
    localparam int CNT_W      = 5;
    localparam int CHAR_W     = 8;
    localparam int SYM_N      = 16;
    localparam int SYM_W      = $clog2(SYM_N);
    localparam int CFG_IDX_W  = 2;
    localparam int OBUF_DEPTH = 3;

    localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  WORD_LEN_C = CNT_W'(WORD_LEN);

    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;

    localparam logic [CNT_W-1:0] RST_MAX_LETTERS = 5'd5;
    localparam logic [CNT_W-1:0] RST_MAX_DIGITS  = 5'd9;
    localparam logic [CNT_W-1:0] RST_MAX_REPEAT  = 5'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LETTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPEAT  = 2'd2;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [SYM_W-1:0] t_sym;

    // histogram write / clear request into the memory
    typedef struct packed {
        logic en;
        logic clr;
        t_sym addr;
        t_cnt data;
    } t_hist_wr;

    function automatic t_cnt sat_inc(input t_cnt v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + t_cnt'(1);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        is_letter = (c >= CH_UPPER_A) && (c <= CH_UPPER_F);
    endfunction

    // '0'..'9' -> 0..9, 'A'..'F' -> 10..15
    function automatic t_sym sym_index(input logic [CHAR_W-1:0] c);
        sym_index = is_digit(c) ? c[SYM_W-1:0] : t_sym'(c[SYM_W-1:0] + t_sym'(9));
    endfunction

endpackage

/* rtl/core/hkcf_if.sv */
// hkcf_if: valid/ready channel interfaces for key characters and verdicts
// depends on hkcf_pkg
interface hkcf_in_if;
    logic                       valid;
    logic                       ready;
    logic [hkcf_pkg::CHAR_W-1:0] ch;
    logic                       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface hkcf_out_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

/* rtl/core/hkcf_hist_ram.sv */
// hkcf_hist_ram: 16-entry symbol histogram memory, registered read
// per-entry valid bits give the zero value after reset or a per-key clear; uses hkcf_pkg
module hkcf_hist_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hkcf_pkg::t_sym     i_rd_addr,
    input  hkcf_pkg::t_hist_wr i_wr,
    output hkcf_pkg::t_cnt     o_rd_data
);
    import hkcf_pkg::*;

    t_cnt             mem [SYM_N];
    logic [SYM_N-1:0] r_vld;
    t_cnt             r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_vld[i_rd_addr] ? mem[i_rd_addr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clr) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/hkcf_out_buf.sv */
// hkcf_out_buf: three-entry verdict buffer between the check stage and the output channel
// depends on hkcf_pkg and hkcf_out_if
module hkcf_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_push_res,
    output logic [1:0]        o_count,
    hkcf_out_if.source        o_out
);
    import hkcf_pkg::*;

    logic       r_buf [OBUF_DEPTH];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == 2'(OBUF_DEPTH - 1)) ? 2'd0 : r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= (r_rp == 2'(OBUF_DEPTH - 1)) ? 2'd0 : r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.valid_res = r_buf[r_rp];
    assign o_count         = r_cnt;

endmodule

/* rtl/core/hex_key_candidate_filter_top.sv */
// hex_key_candidate_filter_top: hex key candidate check, one character item per cycle while the input is not stalled
// each key's verdict item is formed in stage 1 from its last character and written to the verdict buffer
// throughput: 1 item per cycle unless the input stalls; stage 0 reads the histogram entry, stage 1 updates it
// back-to-back hits on the same symbol are forwarded around the memory read
// input stalls only while the verdict buffer and the check stage hold three verdicts
// reset (synchronous, active low): limits return to 5/9/3, key state and histogram clear
module hex_key_candidate_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hkcf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hkcf_pkg::CNT_W-1:0]        i_cfg_data,
    hkcf_in_if.sink                           i_in,
    hkcf_out_if.source                        o_out
);
    import hkcf_pkg::*;

    // limits
    t_cnt r_max_letters;
    t_cnt r_max_digits;
    t_cnt r_max_repeat;

    // stage 1 item
    logic              r_s1_vld;
    logic [CHAR_W-1:0] r_s1_ch;
    logic              r_s1_last;
    logic              r_s1_dig;
    logic              r_s1_let;
    t_sym              r_s1_idx;
    logic              r_key_new;
    logic              r_fwd_hit;
    t_cnt              r_fwd_val;

    // per-key state
    logic [CHAR_W-1:0] r_prev_char;
    logic [1:0]        r_run;
    t_cnt              r_letters;
    t_cnt              r_digits;
    t_cnt              r_chars;
    logic              r_failed;

    logic              accept;
    logic [1:0]        buf_cnt;
    logic [2:0]        pending;
    logic              in_dig;
    logic              in_let;
    t_sym              in_idx;
    t_cnt              rd_data;
    t_cnt              hist_base;
    t_cnt              hist_new;
    t_hist_wr          hist_wr;
    logic [1:0]        n_run;
    t_cnt              n_letters;
    t_cnt              n_digits;
    t_cnt              n_chars;
    logic              n_failed;
    logic              s1_hex;
    logic              verdict;

    assign pending    = {1'b0, buf_cnt} + {2'b0, r_s1_vld & r_s1_last};
    assign i_in.ready = (pending < 3'(OBUF_DEPTH));
    assign accept     = i_in.valid && i_in.ready;

    assign in_dig = is_digit(i_in.ch);
    assign in_let = is_letter(i_in.ch);
    assign in_idx = sym_index(i_in.ch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_letters <= RST_MAX_LETTERS;
            r_max_digits  <= RST_MAX_DIGITS;
            r_max_repeat  <= RST_MAX_REPEAT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_LETTERS: r_max_letters <= i_cfg_data;
                CFG_MAX_DIGITS:  r_max_digits  <= i_cfg_data;
                CFG_MAX_REPEAT:  r_max_repeat  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: capture the item, launch the histogram read, decide forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ch   <= i_in.ch;
            r_s1_last <= i_in.last;
            r_s1_dig  <= in_dig;
            r_s1_let  <= in_let;
            r_s1_idx  <= in_idx;
            // previous item ends its key: this one starts from an empty histogram
            r_key_new <= r_s1_vld && r_s1_last;
            r_fwd_hit <= r_s1_vld && !r_s1_last && s1_hex && (r_s1_idx == in_idx);
            r_fwd_val <= hist_new;
        end
    end

    hkcf_hist_ram u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (in_idx),
        .i_wr      (hist_wr),
        .o_rd_data (rd_data)
    );

    // stage 1: update key state and the histogram entry
    assign s1_hex    = r_s1_dig || r_s1_let;
    assign hist_base = r_key_new ? '0 : (r_fwd_hit ? r_fwd_val : rd_data);
    assign hist_new  = sat_inc(hist_base);

    always_comb begin
        if ((r_chars != '0) && (r_s1_ch == r_prev_char)) begin
            n_run = (r_run == 2'd3) ? 2'd3 : r_run + 2'd1;
        end else begin
            n_run = 2'd1;
        end
        n_chars   = sat_inc(r_chars);
        n_letters = r_s1_let ? sat_inc(r_letters) : r_letters;
        n_digits  = r_s1_dig ? sat_inc(r_digits) : r_digits;
        n_failed  = r_failed || (n_run == 2'd3) || !s1_hex
                    || (r_s1_let && (n_letters > r_max_letters))
                    || (r_s1_dig && (n_digits > r_max_digits))
                    || (s1_hex && (hist_new > r_max_repeat));
        verdict   = !n_failed && (n_chars == WORD_LEN_C);

        hist_wr.en   = r_s1_vld && s1_hex && !r_s1_last;
        hist_wr.clr  = r_s1_vld && r_s1_last;
        hist_wr.addr = r_s1_idx;
        hist_wr.data = hist_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_s1_vld && r_s1_last)) begin
            r_prev_char <= '0;
            r_run       <= '0;
            r_letters   <= '0;
            r_digits    <= '0;
            r_chars     <= '0;
            r_failed    <= 1'b0;
        end else if (r_s1_vld) begin
            r_prev_char <= r_s1_ch;
            r_run       <= n_run;
            r_letters   <= n_letters;
            r_digits    <= n_digits;
            r_chars     <= n_chars;
            r_failed    <= n_failed;
        end
    end

    hkcf_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_s1_vld && r_s1_last),
        .i_push_res (verdict),
        .o_count    (buf_cnt),
        .o_out      (o_out)
    );

endmodule

/* tb/hex_key_candidate_filter_top_test.sv */
// hex_key_candidate_filter_top_test: self-checking test of the hex key candidate filter
// streams key characters, predicts each verdict and compares it against the dut output
// depends on hkcf_pkg, hkcf_in_if / hkcf_out_if and hex_key_candidate_filter_top
module hex_key_candidate_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hkcf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int RETUNE_EVERY = 150;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CNT_W-1:0] i_cfg_data;

    hkcf_in_if  key_chars ();
    hkcf_out_if verdicts ();

    hex_key_candidate_filter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (key_chars),
        .o_out      (verdicts)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the filter: limits and key state
    t_cnt lim_letters, lim_digits, lim_repeat;
    logic [CHAR_W-1:0] last_seen;
    logic [1:0] run_len;
    t_cnt n_letters, n_digits, n_chars;
    t_cnt sym_seen [SYM_N];
    bit broken;

    bit verdicts_due [$];
    int mismatches = 0;
    int chars_sent = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int quiet_cycles = 0;
    bit want_res;

    function automatic t_cnt bump(input t_cnt v);
        return (&v) ? v : v + t_cnt'(1);
    endfunction

    function automatic void forget_key();
        last_seen = '0;
        run_len = '0;
        n_letters = '0;
        n_digits = '0;
        n_chars = '0;
        broken = 1'b0;
        for (int i = 0; i < SYM_N; i++) sym_seen[i] = '0;
    endfunction

    function automatic void absorb_char(input logic [CHAR_W-1:0] c, input logic lst);
        logic digit, letter;
        logic [SYM_W-1:0] sym;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        letter = (c >= CH_UPPER_A) && (c <= CH_UPPER_F);
        if (n_chars != 0 && c == last_seen) begin
            if (run_len != 2'd3) run_len = run_len + 2'd1;
        end else begin
            run_len = 2'd1;
        end
        if (run_len == 2'd3) broken = 1'b1;
        last_seen = c;
        n_chars = bump(n_chars);
        if (digit || letter) begin
            sym = digit ? SYM_W'(c - CH_ZERO) : SYM_W'(c - CH_UPPER_A) + SYM_W'(10);
            if (digit) begin
                n_digits = bump(n_digits);
                if (n_digits > lim_digits) broken = 1'b1;
            end else begin
                n_letters = bump(n_letters);
                if (n_letters > lim_letters) broken = 1'b1;
            end
            sym_seen[sym] = bump(sym_seen[sym]);
            if (sym_seen[sym] > lim_repeat) broken = 1'b1;
        end else begin
            broken = 1'b1;
        end
        if (lst) begin
            verdicts_due.push_back(!broken && n_chars == WORD_LEN_C);
            forget_key();
        end
    endfunction

    // verdict side: random stalls, compare each accepted item with the oldest prediction
    always @(posedge i_clk) begin
        verdicts.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        if (i_rst_n && verdicts.valid && verdicts.ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict item with none pending, expected none, got valid_res=%0b",
                         $time, verdicts.valid_res);
                mismatches++;
            end else begin
                want_res = verdicts_due.pop_front();
                if (verdicts.valid_res !== want_res) begin
                    $display("%0t: valid_res mismatch, expected %0b, got %0b",
                             $time, want_res, verdicts.valid_res);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if ((key_chars.valid && key_chars.ready) || (verdicts.valid && verdicts.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // valid stays high between back-to-back items; lowered only for a gap
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            key_chars.valid <= 1'b0;
            @(posedge i_clk);
        end
        key_chars.valid <= 1'b1;
        key_chars.ch <= c;
        key_chars.last <= lst;
        @(posedge i_clk);
        while (!key_chars.ready) @(posedge i_clk);
        absorb_char(c, lst);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // hold off until every verdict is back and the pipeline has emptied
    task automatic drain_and_settle();
        key_chars.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_limits(input t_cnt l, input t_cnt d, input t_cnt r);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_MAX_LETTERS;
        i_cfg_data <= l;
        @(posedge i_clk);
        lim_letters = l;
        i_cfg_idx <= CFG_MAX_DIGITS;
        i_cfg_data <= d;
        @(posedge i_clk);
        lim_digits = d;
        i_cfg_idx <= CFG_MAX_REPEAT;
        i_cfg_data <= r;
        @(posedge i_clk);
        lim_repeat = r;
        // unused index must leave every limit alone
        i_cfg_idx <= CFG_SPARE;
        i_cfg_data <= t_cnt'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cnt pick_limit(input int lo);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return t_cnt'(lo);
        if (r == 1) return t_cnt'(16);
        if (r == 2) return t_cnt'(31);
        return t_cnt'($urandom_range(lo, 16));
    endfunction

    task automatic random_key();
        int len, kind, pick, r;
        bit sloppy;
        logic [CHAR_W-1:0] c, prev;
        kind = $urandom_range(0, 99);
        if (kind < 75) len = WORD_LEN;
        else if (kind < 85) len = $urandom_range(WORD_LEN - 1, WORD_LEN + 1);
        else if (kind < 95) len = $urandom_range(1, 16);
        else len = $urandom_range(17, 40);   // can run past saturation of the length count
        sloppy = ($urandom_range(0, 99) < 25);
        prev = '0;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (i > 0 && pick < 8) begin
                c = prev;
            end else if (sloppy && pick < 20) begin
                c = CHAR_W'($urandom_range(0, 255));
            end else if (sloppy && pick < 25) begin
                c = CH_LOWER_A + CHAR_W'($urandom_range(0, 5));
            end else begin
                r = $urandom_range(0, 15);
                c = (r < 10) ? CH_ZERO + CHAR_W'(r) : CH_UPPER_A + CHAR_W'(r - 10);
            end
            send_char(c, i == len - 1);
            prev = c;
        end
    endtask

    task automatic test_reset_limits();
        send_text("01234ABCDE");
        send_text("0001");
        // just outside each hex range, plus lower case and the byte extremes
        send_char(8'h2F, 1'b0);
        send_char(8'h3A, 1'b0);
        send_char(8'h40, 1'b0);
        send_char(8'h47, 1'b0);
        send_char(CH_LOWER_A, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("F");
    endtask

    task automatic test_limit_extremes();
        drain_and_settle();
        program_limits('0, '0, '0);
        send_text("9");
        drain_and_settle();
        program_limits('1, '1, '1);
        send_text("AABBCCDDEE");
        drain_and_settle();
        program_limits(t_cnt'(16), t_cnt'(16), t_cnt'(1));
    endtask

    task automatic test_random_keys(input int src_pct, input int sink_pct, input int budget);
        int stop_at, retune_at;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = chars_sent + budget;
        retune_at = chars_sent + RETUNE_EVERY;
        while (chars_sent < stop_at) begin
            random_key();
            if (chars_sent >= retune_at) begin
                drain_and_settle();
                program_limits(pick_limit(0), pick_limit(0), pick_limit(1));
                retune_at = chars_sent + RETUNE_EVERY;
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_MAX_LETTERS;
        i_cfg_data <= '0;
        key_chars.valid <= 1'b0;
        key_chars.ch <= '0;
        key_chars.last <= 1'b0;
        lim_letters = RST_MAX_LETTERS;
        lim_digits = RST_MAX_DIGITS;
        lim_repeat = RST_MAX_REPEAT;
        forget_key();
        src_idle_pct = 23;
        sink_idle_pct = 79;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_limits();
        test_limit_extremes();
        test_random_keys(23, 79, 560);
        drain_and_settle();
        program_limits(RST_MAX_LETTERS, RST_MAX_DIGITS, RST_MAX_REPEAT);
        test_random_keys(79, 23, 580);
        drain_and_settle();
        program_limits(pick_limit(0), pick_limit(0), pick_limit(1));
        test_random_keys(0, 0, 580);

        drain_and_settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
